FILE: rtl/core/nec_ir_edge_capture_decoder_defines.svh
// Assertion macros shared by the NEC IR edge-capture decoder RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef NEC_IR_EDGE_CAPTURE_DECODER_DEFINES_SVH
`define NEC_IR_EDGE_CAPTURE_DECODER_DEFINES_SVH
// Assert that prop holds at every rising clock edge outside reset.
`define NIR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that ante implies cons in the following cycle.
`define NIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/core/nir_pkg.sv
// Package for the NEC IR edge-capture decoder: constants, types, command codes.
// No dependencies.
`default_nettype none
package nir_pkg;
  localparam int EdgeDepthDef = 90;
  localparam logic [19:0] GapResetUs = 20'd12000;
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_GAP    = 2'd1;
  localparam logic [1:0] CFG_ZONE   = 2'd2;
  localparam logic [15:0] SatMax = 16'hFFFF;

  // datapath commands from the controller
  typedef struct packed {
    logic open_frame;   // start a frame using the input item
    logic open_cap;     // capture flag for the opened frame
    logic store_edge;   // write duration/level at edge_count
    logic set_ovf;      // mark overflow and close
    logic upd_last;     // update last-edge time
    logic close_frame;  // idle close
    logic collect;      // clear frame state after a poll
    logic scan_clear;   // reset scan position to 0
    logic scan_rd;      // issue read at scan address
    logic scan_chk;     // check registered read data
    logic scan_next_s;  // advance to next start position
    logic load_out;     // load result register
    logic [1:0] status;
  } nir_cmd_t;

  typedef struct packed {
    logic edge_seen;
    logic capturing;
    logic frame_ready;
    logic overflowed;
    logic gap_exceeded;  // now - last_edge > frame_gap
    logic full;          // edge_count == depth
    logic s_valid;       // s + 65 < edge_count
    logic pos_done;      // the last of the 66 entries is under check
    logic chk_ok;        // current entry in window
  } nir_sts_t;

  function automatic logic in_win(input logic [15:0] v, input logic [15:0] c,
                                  input logic [15:0] t);
    return (v >= c - t) && (v <= c + t);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/nec_ir_edge_capture_decoder.sv
// NEC IR edge-capture decoder top level: config registers, controller, datapath.
// Depends on nir_pkg, nir_ctrl, nir_datapath.
//
// Edge items are taken at one item per cycle while no poll is in progress and no
// result is waiting on the output. A poll that finds no frame or an overflowed
// frame passes through the S_OUT state before its result is raised. A poll that
// decodes walks start positions through the one read port of the capture store:
// an S_POS step per position plus an S_RD and an S_CHK step per entry checked,
// and a full match checks all 66 entries of the window, then passes through
// S_OUT. The next item is held until the result transfer is taken.
`default_nettype none
module nec_ir_edge_capture_decoder #(
  parameter int EDGE_DEPTH = nir_pkg::EdgeDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] time_us, [32] level_now, rest zero
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [1:0] status, [33:2] code, [65:34] frame_start_us,
                                       // [68:66] zone, rest zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic        enable_r;
  logic [19:0] gap_r;
  logic [2:0]  zone_r;
  nir_pkg::nir_cmd_t cmd;
  nir_pkg::nir_sts_t sts;
  logic busy, in_fire;
  logic [1:0] status;
  logic [31:0] code, start;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      gap_r <= nir_pkg::GapResetUs;
      zone_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nir_pkg::CFG_ENABLE: enable_r <= cfg_data[0];
        nir_pkg::CFG_GAP:    gap_r <= cfg_data[19:0];
        nir_pkg::CFG_ZONE:   zone_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  nir_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_cmd(in_tuser),
    .level_now(in_tdata[32]), .enable(enable_r), .sts(sts), .cmd(cmd),
    .busy(busy), .out_valid_r(out_tvalid), .out_ready(out_tready));

  nir_datapath #(.EDGE_DEPTH(EDGE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .time_us(in_tdata[31:0]),
    .level_now(in_tdata[32]), .idle_gap_us(gap_r), .status_r(status),
    .code_r(code), .start_out_r(start));

  assign out_tdata = {3'd0, zone_r, start, code, status};
endmodule
`default_nettype wire

FILE: rtl/core/nir_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module nir_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 90
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/nir_datapath.sv
// Datapath: frame state, capture store, header/bit scan and result register.
// Depends on nir_pkg and nir_ram.
`default_nettype none
module nir_datapath #(
  parameter int EDGE_DEPTH = nir_pkg::EdgeDepthDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nir_pkg::nir_cmd_t cmd,
  output nir_pkg::nir_sts_t      sts,
  input  wire logic [31:0]       time_us,
  input  wire logic              level_now,
  input  wire logic [19:0]       idle_gap_us,
  output logic [1:0]             status_r,
  output logic [31:0]            code_r,
  output logic [31:0]            start_out_r
);
  localparam int AW = $clog2(EDGE_DEPTH);
  localparam int CW = $clog2(EDGE_DEPTH + 1);

  logic        edge_seen_r, capturing_r, ready_r, ovf_r;
  logic [31:0] last_r, start_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] s_r;     // start position
  logic [6:0]    k_r;     // offset within the 66-entry window
  logic [31:0]   acc_r;
  logic [31:0]   dur;
  logic [15:0]   dur_sat;
  logic [AW-1:0] addr;
  logic          we;
  logic [16:0]   rdata;
  logic [16:0]   wdata;
  logic [6:0]    k_chk_r;

  assign dur = time_us - last_r;
  assign dur_sat = (dur > 32'(nir_pkg::SatMax)) ? nir_pkg::SatMax : dur[15:0];
  assign we = cmd.store_edge;
  assign wdata = {~level_now, dur_sat};
  // read the entry latched in k_chk_r so the data lines up with the check
  assign addr = we ? count_r[AW-1:0] : AW'(s_r + AW'(k_chk_r));

  nir_ram #(.WIDTH(17), .DEPTH(EDGE_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  // check entry at offset k_chk_r
  logic lv;
  logic [15:0] dv;
  logic ok;
  assign lv = rdata[16];
  assign dv = rdata[15:0];
  always_comb begin
    if (k_chk_r == 7'd0)
      ok = !lv && nir_pkg::in_win(dv, 16'd9000, 16'd1800);
    else if (k_chk_r == 7'd1)
      ok = lv && nir_pkg::in_win(dv, 16'd4500, 16'd1200);
    else if (!k_chk_r[0])
      ok = !lv && nir_pkg::in_win(dv, 16'd560, 16'd300);
    else
      ok = lv && (nir_pkg::in_win(dv, 16'd560, 16'd350) ||
                  nir_pkg::in_win(dv, 16'd1690, 16'd650));
  end

  assign sts.edge_seen = edge_seen_r;
  assign sts.capturing = capturing_r;
  assign sts.frame_ready = ready_r;
  assign sts.overflowed = ovf_r;
  assign sts.gap_exceeded = dur > {12'd0, idle_gap_us};
  assign sts.full = count_r == CW'(EDGE_DEPTH);
  assign sts.s_valid = ({1'b0, 7'(s_r)} + 8'd65) < 8'(count_r);
  assign sts.pos_done = k_chk_r == 7'd65;
  assign sts.chk_ok = ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_seen_r <= 1'b0;
      capturing_r <= 1'b0;
      ready_r <= 1'b0;
      ovf_r <= 1'b0;
      last_r <= '0;
      start_r <= '0;
      count_r <= '0;
      s_r <= '0;
      k_r <= '0;
      k_chk_r <= '0;
    end else begin
      if (cmd.open_frame) begin
        capturing_r <= cmd.open_cap;
        ready_r <= 1'b0;
        ovf_r <= 1'b0;
        count_r <= '0;
        start_r <= time_us;
        last_r <= time_us;
        edge_seen_r <= 1'b1;
      end else begin
        if (cmd.store_edge) count_r <= count_r + CW'(1);
        if (cmd.set_ovf) begin
          ovf_r <= 1'b1;
          ready_r <= 1'b1;
          capturing_r <= 1'b0;
        end
        if (cmd.upd_last) last_r <= time_us;
        if (cmd.close_frame) begin
          ready_r <= 1'b1;
          capturing_r <= 1'b0;
        end
        if (cmd.collect) begin
          ready_r <= 1'b0;
          capturing_r <= 1'b0;
          ovf_r <= 1'b0;
          start_r <= '0;
          last_r <= '0;
          edge_seen_r <= 1'b0;
        end
      end
      if (cmd.scan_clear) begin
        s_r <= '0;
        k_r <= '0;
      end else if (cmd.scan_next_s) begin
        s_r <= s_r + AW'(1);
        k_r <= '0;
      end else if (cmd.scan_rd) begin
        k_chk_r <= k_r;
        k_r <= k_r + 7'd1;
      end
      if (cmd.load_out && cmd.collect) count_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_next_s || cmd.scan_clear) acc_r <= '0;
    else if (cmd.scan_chk && k_chk_r[0] && k_chk_r != 7'd1)
      acc_r <= {acc_r[30:0], dv > 16'd1000};
    if (cmd.load_out) begin
      status_r <= cmd.status;
      // a decode loads on the last bit's check, so take that bit directly
      code_r <= (cmd.status == nir_pkg::ST_OK) ? {acc_r[30:0], dv > 16'd1000} : '0;
      start_out_r <= (cmd.status == nir_pkg::ST_NONE) ? '0 : start_r;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/nir_ctrl.sv
// Controller FSM: edge handling, poll close, scan sequencing, output handshake.
// Depends on nir_pkg and the assertion macro header.
`default_nettype none
`include "nec_ir_edge_capture_decoder_defines.svh"
module nir_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              in_cmd,
  input  wire logic              level_now,
  input  wire logic              enable,
  input  wire nir_pkg::nir_sts_t sts,
  output nir_pkg::nir_cmd_t      cmd,
  output logic                   busy,
  output logic                   out_valid_r,
  input  wire logic              out_ready
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POS  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic out_valid_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && !in_cmd && enable) begin
          if (!sts.edge_seen) begin
            cmd.open_frame = 1'b1;
            cmd.open_cap = !level_now;
          end else if (sts.gap_exceeded && !level_now) begin
            cmd.open_frame = 1'b1;
            cmd.open_cap = 1'b1;
          end else begin
            cmd.upd_last = 1'b1;
            if (sts.capturing && !sts.frame_ready) begin
              if (sts.full) cmd.set_ovf = 1'b1;
              else cmd.store_edge = 1'b1;
            end
          end
        end else if (in_fire && in_cmd) begin
          if (!enable) begin
            cmd.load_out = 1'b1;
            cmd.status = nir_pkg::ST_NONE;
            state_nxt = S_OUT;
          end else if (sts.frame_ready || (sts.capturing && sts.edge_seen &&
                                           sts.gap_exceeded)) begin
            if (sts.overflowed && sts.frame_ready) begin
              cmd.load_out = 1'b1;
              cmd.collect = 1'b1;
              cmd.status = nir_pkg::ST_OVF;
              state_nxt = S_OUT;
            end else begin
              cmd.close_frame = 1'b1;
              cmd.scan_clear = 1'b1;
              state_nxt = S_POS;
            end
          end else begin
            cmd.load_out = 1'b1;
            cmd.status = nir_pkg::ST_NONE;
            state_nxt = S_OUT;
          end
        end
      end
      S_POS: begin
        if (!sts.s_valid) begin
          cmd.load_out = 1'b1;
          cmd.collect = 1'b1;
          cmd.status = nir_pkg::ST_FAIL;
          state_nxt = S_OUT;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        cmd.scan_chk = 1'b1;
        if (!sts.chk_ok) begin
          cmd.scan_next_s = 1'b1;
          state_nxt = S_POS;
        end else if (sts.pos_done) begin
          state_nxt = S_OUT;
          cmd.load_out = 1'b1;
          cmd.collect = 1'b1;
          cmd.status = nir_pkg::ST_OK;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // ST_OK loads in the same cycle as the last shift: code register takes the shifted acc
    if (cmd.load_out) out_valid_nxt = 1'b0;
    if (state_r == S_OUT && state_nxt == S_IDLE) out_valid_nxt = 1'b1;
  end

  assign busy = state_r != S_IDLE || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `NIR_ASSERT(a_no_accept_busy, clk, rst_n, !(in_fire && state_r != S_IDLE), "accept while busy")
  `NIR_ASSERT_NEXT(a_load_goes_out, clk, rst_n, cmd.load_out, state_r == S_OUT, "load without out")
  `NIR_ASSERT(a_one_write, clk, rst_n, !(cmd.store_edge && cmd.set_ovf), "store and overflow")
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for nec_ir_edge_capture_decoder: streams edge and poll
// items, predicts every poll answer in SystemVerilog and checks each result.
// Depends on nir_pkg and the decoder RTL only.
`timescale 1ns / 1ps
module testbench;
  localparam int StoreDepth = 90;
  localparam int WatchLimit = 40000;
  localparam logic CmdEdge = 1'b0;
  localparam logic CmdPoll = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] t;
    logic        lvl;
  } ir_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] code;
    logic [31:0] start;
    logic [2:0]  zone;
  } ir_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = nir_pkg::CFG_ENABLE;
  logic [31:0] cfg_data = '0;

  nec_ir_edge_capture_decoder uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  ir_item_t   pending_items[$];
  ir_answer_t expected_answers[$];
  bit         steady = 1'b0;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         answers_seen = 0;

  // predicted decoder state and registers
  logic        m_enable = 1'b1;
  logic [19:0] m_gap = nir_pkg::GapResetUs;
  logic [2:0]  m_zone = 3'd0;
  logic        m_seen = 1'b0;
  logic [31:0] m_last = '0;
  logic [31:0] m_start = '0;
  logic        m_capturing = 1'b0;
  logic        m_ready = 1'b0;
  logic        m_ovf = 1'b0;
  int          m_count = 0;
  logic [15:0] dur_mem[StoreDepth];
  logic        lvl_mem[StoreDepth];

  // stimulus bookkeeping
  logic [31:0] cur_t = '0;
  int          items_pushed = 0;
  int          polls_pushed = 0;

  // the gap the stimulus plans against: the last value written
  logic [19:0] gap_plan = nir_pkg::GapResetUs;
  function automatic int unsigned m_gap_now();
    return gap_plan;
  endfunction

  function automatic bit in_window(logic [15:0] v, int c, int t);
    return int'(v) >= c - t && int'(v) <= c + t;
  endfunction

  function automatic bit nec_search(int n, output logic [31:0] code);
    logic [31:0] acc;
    bit good;
    int m;
    code = '0;
    for (int s = 0; s + 65 < n; s++) begin
      if (lvl_mem[s] != 1'b0 || lvl_mem[s+1] != 1'b1) continue;
      if (!in_window(dur_mem[s], 9000, 1800) || !in_window(dur_mem[s+1], 4500, 1200)) continue;
      acc = '0;
      good = 1'b1;
      for (int b = 0; b < 32 && good; b++) begin
        m = s + 2 + 2 * b;
        if (lvl_mem[m] != 1'b0 || lvl_mem[m+1] != 1'b1 || !in_window(dur_mem[m], 560, 300) ||
            !(in_window(dur_mem[m+1], 560, 350) || in_window(dur_mem[m+1], 1690, 650)))
          good = 1'b0;
        else
          acc = {acc[30:0], dur_mem[m+1] > 16'd1000};
      end
      if (good) begin
        code = acc;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic open_capture(bit cap, logic [31:0] now);
    m_capturing = cap;
    m_ready = 1'b0;
    m_ovf = 1'b0;
    m_count = 0;
    m_start = now;
    m_last = now;
    m_seen = 1'b1;
  endtask

  task automatic decode_step(ir_item_t it);
    logic [31:0] dur;
    logic [31:0] code;
    ir_answer_t ans;
    if (it.cmd == CmdEdge) begin
      if (!m_enable) return;
      if (!m_seen) begin
        open_capture(it.lvl == 1'b0, it.t);
        return;
      end
      dur = it.t - m_last;
      if (dur > {12'd0, m_gap} && it.lvl == 1'b0) begin
        open_capture(1'b1, it.t);
        return;
      end
      if (m_capturing && !m_ready) begin
        if (m_count < StoreDepth) begin
          dur_mem[m_count] = dur > 32'hFFFF ? nir_pkg::SatMax : dur[15:0];
          lvl_mem[m_count] = ~it.lvl;
          m_count++;
        end else begin
          m_ovf = 1'b1;
          m_ready = 1'b1;
          m_capturing = 1'b0;
        end
      end
      m_last = it.t;
    end else begin
      ans = '{status: nir_pkg::ST_NONE, code: '0, start: '0, zone: m_zone};
      if (m_enable) begin
        if (m_capturing && !m_ready && m_seen && (it.t - m_last) > {12'd0, m_gap}) begin
          m_ready = 1'b1;
          m_capturing = 1'b0;
        end
        if (m_ready) begin
          ans.start = m_start;
          if (m_ovf) ans.status = nir_pkg::ST_OVF;
          else if (nec_search(m_count, code)) begin
            ans.status = nir_pkg::ST_OK;
            ans.code = code;
          end else ans.status = nir_pkg::ST_FAIL;
          m_ready = 1'b0;
          m_capturing = 1'b0;
          m_ovf = 1'b0;
          m_count = 0;
          m_start = '0;
          m_last = '0;
          m_seen = 1'b0;
        end
      end
      expected_answers.push_back(ans);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_items.size() > 0 && (steady || $urandom_range(99) >= 29)) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_items[0].cmd;
        in_tdata <= {7'd0, pending_items[0].lvl, pending_items[0].t};
        void'(pending_items.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= rst_n && (steady || $urandom_range(99) >= 29);
  end

  // monitor: predict on input transfers, check on result transfers
  always @(posedge clk) begin
    ir_answer_t got;
    ir_answer_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nir_pkg::CFG_ENABLE: m_enable = cfg_data[0];
          nir_pkg::CFG_GAP:    m_gap = cfg_data[19:0];
          nir_pkg::CFG_ZONE:   m_zone = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        decode_step('{cmd: in_tuser, t: in_tdata[31:0], lvl: in_tdata[32]});
      if (out_tvalid && out_tready) begin
        answers_seen++;
        got = '{status: out_tdata[1:0], code: out_tdata[33:2], start: out_tdata[65:34],
                zone: out_tdata[68:66]};
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %h", out_tdata);
        end else begin
          want = expected_answers.pop_front();
          if (got.status !== want.status || got.code !== want.code ||
              got.start !== want.start || got.zone !== want.zone || out_tdata[71:69] !== 3'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: status %0d/%0d code %h/%h start %h/%h zone %0d/%0d",
                       got.status, want.status, got.code, want.code,
                       got.start, want.start, got.zone, want.zone);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WatchLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic push(logic cmd, logic [31:0] t, logic lvl);
    pending_items.push_back('{cmd: cmd, t: t, lvl: lvl});
    items_pushed++;
    if (cmd == CmdPoll) polls_pushed++;
  endtask

  task automatic push_edge(int unsigned dt, logic lvl);
    cur_t += dt;
    push(CmdEdge, cur_t, lvl);
  endtask

  task automatic push_poll(int unsigned dt);
    cur_t += dt;
    push(CmdPoll, cur_t, 1'($urandom_range(1)));
  endtask

  function automatic int unsigned jitter(int c, int t);
    case ($urandom_range(3))
      0: return c - t;
      1: return c + t;
      default: return $urandom_range(c + t, c - t);
    endcase
  endfunction

  // well-formed NEC burst, optionally with one broken bit, then a closing poll
  task automatic nec_frame(logic [31:0] code, bit corrupt);
    int bad_bit;
    bad_bit = corrupt ? $urandom_range(31) : -1;
    if ($urandom_range(9) == 0) cur_t = 32'hFFFF_FFFF - $urandom_range(20000);
    push_edge(m_gap_now() + 1 + $urandom_range(500), 1'b0);
    if ($urandom_range(3) == 0) begin
      push_edge($urandom_range(3000, 100), 1'b1);
      push_edge($urandom_range(3000, 100), 1'b0);
    end
    push_edge(jitter(9000, 1800), 1'b1);
    push_edge(jitter(4500, 1200), 1'b0);
    for (int b = 31; b >= 0; b--) begin
      push_edge(b == bad_bit ? 861 + $urandom_range(400) : jitter(560, 300), 1'b1);
      push_edge(code[b] ? jitter(1690, 650) : jitter(560, 350), 1'b0);
    end
    push_edge(560, 1'b1);
    if ($urandom_range(3) == 0) push_poll($urandom_range(m_gap_now()));
    push_poll(m_gap_now() + 1 + $urandom_range(100));
  endtask

  task automatic overflow_frame();
    push_edge(m_gap_now() + 1, 1'b0);
    for (int k = 0; k < StoreDepth + 2 + $urandom_range(3); k++)
      push_edge($urandom_range(900, 300), k[0] ? 1'b0 : 1'b1);
    push_poll(m_gap_now() + 1);
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(8, 2);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(5))
        0: push(CmdEdge, $urandom, 1'($urandom_range(1)));
        1: push_poll($urandom_range(m_gap_now() + 2000));
        2: push_poll(m_gap_now() + 1);
        default: push_edge($urandom_range(80000), 1'($urandom_range(1)));
      endcase
    end
    push_poll(m_gap_now() + 1 + $urandom_range(50));
  endtask

  task automatic random_phase(int n_items, int n_polls, bit frames_ok);
    int base_items;
    int base_polls;
    base_items = items_pushed;
    base_polls = polls_pushed;
    while (items_pushed - base_items < n_items || polls_pushed - base_polls < n_polls) begin
      case (frames_ok ? $urandom_range(9) : 9)
        0, 1, 2, 3, 4: nec_frame($urandom, 1'b0);
        5:             nec_frame($urandom, 1'b1);
        6:             overflow_frame();
        default:       noise_burst();
      endcase
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || answers_seen < polls_pushed)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == nir_pkg::CFG_GAP) gap_plan = val[19:0];
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first edge at time zero on a high level, polls with no frame,
    // then short captured bursts, one across the time wrap, that fail to decode
    push(CmdEdge, 32'd0, 1'b1);
    push(CmdPoll, 32'd5, 1'b0);
    push(CmdEdge, 32'd20000, 1'b0);
    push(CmdEdge, 32'd29000, 1'b1);
    push(CmdEdge, 32'd33500, 1'b0);
    push(CmdPoll, 32'd40000, 1'b1);
    push(CmdPoll, 32'd45501, 1'b0);
    push(CmdPoll, 32'd60000, 1'b0);
    push(CmdEdge, 32'hFFFF_FFFF, 1'b0);
    push(CmdEdge, 32'd100, 1'b1);
    push(CmdEdge, 32'd100, 1'b0);
    push(CmdPoll, 32'd12100, 1'b1);
    push(CmdPoll, 32'd12101, 1'b1);
    cur_t = 32'd12101;
    drain();

    write_reg(nir_pkg::CFG_ENABLE, 32'd1);
    write_reg(nir_pkg::CFG_GAP, 32'd12000);
    write_reg(nir_pkg::CFG_ZONE, 32'd0);
    steady = 1'b1;
    nec_frame(32'hFFFF_FFFF, 1'b0);
    overflow_frame();
    drain();
    steady = 1'b0;

    write_reg(nir_pkg::CFG_GAP, 32'd6000);
    write_reg(nir_pkg::CFG_ZONE, 32'd7);
    random_phase(30, 1, 1'b1);
    drain();

    // widest gap: long idle spans stay within the gap, so no capture starts on them
    write_reg(nir_pkg::CFG_GAP, 32'hF_FFFF);
    write_reg(nir_pkg::CFG_ZONE, 32'd3);
    push_edge(70000, 1'b1);
    push_edge(200000, 1'b0);
    random_phase(10, 2, 1'b0);
    drain();

    write_reg(nir_pkg::CFG_ENABLE, 32'd0);
    write_reg(nir_pkg::CFG_ZONE, 32'd5);
    random_phase(10, 3, 1'b0);
    drain();

    write_reg(nir_pkg::CFG_ENABLE, 32'd1);
    write_reg(nir_pkg::CFG_GAP, 32'd0);
    random_phase(10, 3, 1'b0);
    drain();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && expected_answers.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
